// File: design/lscl_pkg.sv
// Shared constants, state type and update record for the sector cache lookup.
package lscl_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int TAG_W      = 31;
    localparam int SLOT_OUT_W = 3;
    localparam int CNT_W      = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    // Recency and valid update issued once per request
    typedef struct packed {
        logic              en;
        logic              fill;
        logic [SLOT_W-1:0] pos;
        logic [SLOT_W-1:0] slot;
    } upd_t;

endpackage

// File: design/lscl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lscl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lscl_recency.sv
// Recency order of the slots and per-slot valid bits.
module lscl_recency (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [lscl_pkg::SLOT_W-1:0] rd_pos,
    input  lscl_pkg::upd_t            upd,
    output logic [lscl_pkg::SLOT_W-1:0] rd_slot,
    output logic                      rd_valid
);

    logic [lscl_pkg::SLOT_W-1:0] order_reg  [lscl_pkg::SLOTS];
    logic [lscl_pkg::SLOT_W-1:0] order_next [lscl_pkg::SLOTS];
    logic [lscl_pkg::SLOTS-1:0]  valid_reg;
    logic [lscl_pkg::SLOTS-1:0]  valid_next;

    // Look up the slot at the walk position
    assign rd_slot  = order_reg[rd_pos];
    assign rd_valid = valid_reg[rd_slot];

    // Move the chosen slot to the front, shift the ones ahead of it back
    always_comb begin
        for (int i = 0; i < lscl_pkg::SLOTS; i++) begin
            order_next[i] = order_reg[i];
        end
        if (upd.en) begin
            for (int i = 1; i < lscl_pkg::SLOTS; i++) begin
                if (lscl_pkg::SLOT_W'(i) <= upd.pos) begin
                    order_next[i] = order_reg[i-1];
                end
            end
            order_next[0] = upd.slot;
        end
    end

    // Mark a filled slot valid
    always_comb begin
        valid_next = valid_reg;
        if (upd.en && upd.fill) begin
            valid_next[upd.slot] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lscl_pkg::SLOTS; i++) begin
                order_reg[i] <= lscl_pkg::SLOT_W'(i);
            end
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < lscl_pkg::SLOTS; i++) begin
                order_reg[i] <= order_next[i];
            end
            valid_reg <= valid_next;
        end
    end

endmodule

// File: design/lru_sector_cache_lookup.sv
// Fully associative LRU sector cache lookup: walks the recency order, reports slot and hit.
//
// Each request beat carries a sector number; the block walks the slots from most to
// least recently used, stopping at the first valid slot whose tag matches (hit) or at
// the first empty slot (miss), else taking the least recent slot (miss). The chosen
// slot moves to the front and, on a miss, takes the sector as its new tag. A walk
// reads from zero to SLOTS tags, each from the single read port of the tag RAM, one
// read and one compare per slot, and the result can wait for the output register to
// free up. One request is in flight at a time; the next request is taken while the
// previous result still waits in the output register. Tags live in a RAM with no
// reset; valid bits clear and the recency order returns to slot index order at
// reset, so the block is ready right after reset. The result beat also carries
// wrapping 32-bit hit and miss totals that include the current request.
module lru_sector_cache_lookup (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lscl_pkg::IN_TDATA_W-1:0]    s_tdata,   // [30:0] sector_number
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] slot, [3] hit, [35:4] hit_total, [67:36] miss_total
    output logic [lscl_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    lscl_pkg::state_t state_reg, state_next;

    logic [lscl_pkg::TAG_W-1:0]  sector_reg, sector_next;
    logic [lscl_pkg::SLOT_W-1:0] pos_reg, pos_next;
    logic [lscl_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic                        hit_reg, hit_next;
    logic [lscl_pkg::CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [lscl_pkg::CNT_W-1:0]  miss_cnt_reg, miss_cnt_next;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [lscl_pkg::SLOT_OUT_W-1:0] m_slot_reg, m_slot_next;
    logic                            m_hit_reg, m_hit_next;
    logic [lscl_pkg::CNT_W-1:0]      m_hit_tot_reg, m_hit_tot_next;
    logic [lscl_pkg::CNT_W-1:0]      m_miss_tot_reg, m_miss_tot_next;

    logic [lscl_pkg::SLOT_W-1:0] rd_slot;
    logic                        rd_valid;
    logic [lscl_pkg::TAG_W-1:0]  tag_rdata;
    lscl_pkg::upd_t              upd;

    logic tag_match;
    logic out_free;
    logic cap_in;
    logic rd_issue;
    logic empty_found;
    logic match_found;
    logic walk_end;
    logic advance;
    logic commit;

    logic [lscl_pkg::SLOT_OUT_W+lscl_pkg::SLOT_W-1:0] slot_ext;

    // Recency order and valid bits
    lscl_recency u_recency (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_pos   (pos_reg),
        .upd      (upd),
        .rd_slot  (rd_slot),
        .rd_valid (rd_valid)
    );

    // Tag store; the write at commit lands before the next read can issue
    lscl_ram #(
        .WIDTH (lscl_pkg::TAG_W),
        .DEPTH (lscl_pkg::SLOTS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (commit && !hit_reg),
        .waddr (slot_reg),
        .wdata (sector_reg),
        .re    (rd_issue),
        .raddr (rd_slot),
        .rdata (tag_rdata)
    );

    assign tag_match = (tag_rdata == sector_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lscl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = lscl_pkg::ST_READ;
                end
            end
            lscl_pkg::ST_READ: begin
                state_next = rd_valid ? lscl_pkg::ST_CMP : lscl_pkg::ST_DONE;
            end
            lscl_pkg::ST_CMP: begin
                if (tag_match || pos_reg == lscl_pkg::LAST_POS) begin
                    state_next = lscl_pkg::ST_DONE;
                end else begin
                    state_next = lscl_pkg::ST_READ;
                end
            end
            lscl_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = lscl_pkg::ST_IDLE;
                end
            end
            default: state_next = lscl_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready    = 1'b0;
        cap_in      = 1'b0;
        rd_issue    = 1'b0;
        empty_found = 1'b0;
        match_found = 1'b0;
        walk_end    = 1'b0;
        advance     = 1'b0;
        commit      = 1'b0;
        case (state_reg)
            lscl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cap_in   = s_tvalid;
            end
            lscl_pkg::ST_READ: begin
                rd_issue    = rd_valid;
                empty_found = !rd_valid;
            end
            lscl_pkg::ST_CMP: begin
                match_found = tag_match;
                walk_end    = !tag_match && (pos_reg == lscl_pkg::LAST_POS);
                advance     = !tag_match && (pos_reg != lscl_pkg::LAST_POS);
            end
            lscl_pkg::ST_DONE: begin
                commit = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Walk datapath and counters
    always_comb begin
        sector_next   = cap_in ? s_tdata[lscl_pkg::TAG_W-1:0] : sector_reg;
        pos_next      = pos_reg;
        slot_next     = (state_reg == lscl_pkg::ST_READ) ? rd_slot : slot_reg;
        hit_next      = hit_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (cap_in) begin
            pos_next = '0;
        end else if (advance) begin
            pos_next = pos_reg + lscl_pkg::SLOT_W'(1);
        end
        if (cap_in || empty_found || walk_end) begin
            hit_next = 1'b0;
        end else if (match_found) begin
            hit_next = 1'b1;
        end
        if (commit) begin
            if (hit_reg) begin
                hit_cnt_next = hit_cnt_reg + lscl_pkg::CNT_W'(1);
            end else begin
                miss_cnt_next = miss_cnt_reg + lscl_pkg::CNT_W'(1);
            end
        end
    end

    assign upd.en   = commit;
    assign upd.fill = !hit_reg;
    assign upd.pos  = pos_reg;
    assign upd.slot = slot_reg;

    assign slot_ext = {{lscl_pkg::SLOT_OUT_W{1'b0}}, slot_reg};

    // Output register: load on commit, drop once the beat is taken
    always_comb begin
        m_tvalid_next   = m_tvalid_reg;
        m_slot_next     = m_slot_reg;
        m_hit_next      = m_hit_reg;
        m_hit_tot_next  = m_hit_tot_reg;
        m_miss_tot_next = m_miss_tot_reg;
        if (commit) begin
            m_tvalid_next   = 1'b1;
            m_slot_next     = slot_ext[lscl_pkg::SLOT_OUT_W-1:0];
            m_hit_next      = hit_reg;
            m_hit_tot_next  = hit_cnt_next;
            m_miss_tot_next = miss_cnt_next;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lscl_pkg::ST_IDLE;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sector_reg     <= sector_next;
        pos_reg        <= pos_next;
        slot_reg       <= slot_next;
        hit_reg        <= hit_next;
        m_slot_reg     <= m_slot_next;
        m_hit_reg      <= m_hit_next;
        m_hit_tot_reg  <= m_hit_tot_next;
        m_miss_tot_reg <= m_miss_tot_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = lscl_pkg::OUT_TDATA_W'({m_miss_tot_reg, m_hit_tot_reg, m_hit_reg,
                                              m_slot_reg});

    // The walk never runs past the least recent position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lscl_pkg::ST_CMP && pos_reg == lscl_pkg::LAST_POS)
            |=> state_reg == lscl_pkg::ST_DONE)
        else $error("walk continued past last position");

    // An empty slot ends the walk as a miss
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lscl_pkg::ST_READ && !rd_valid)
            |=> (state_reg == lscl_pkg::ST_DONE && !hit_reg))
        else $error("empty slot not taken as a miss");

    // A committed miss bumps the miss count by one and leaves the hit count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && !hit_reg)
            |=> (miss_cnt_reg == $past(miss_cnt_reg) + lscl_pkg::CNT_W'(1))
                && $stable(hit_cnt_reg))
        else $error("miss count update wrong");

    // Every commit presents a result beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (m_tvalid_reg && state_reg == lscl_pkg::ST_IDLE))
        else $error("commit without result beat");

endmodule

// File: tb/sv/tb_lru_sector_cache_lookup.sv
// Self-checking testbench for the LRU sector cache lookup: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_lru_sector_cache_lookup;

    localparam int RANDOM_ITEMS = 1430;
    localparam int CALM_ITEMS   = 200;   // tail of the run with no idling
    localparam int CHOKE_AT     = 300;   // random item that starts the long receiver hold-off
    localparam int CHOKE_CYCLES = 400;
    localparam int TAIL_CYCLES  = 40;

    // Laid out like m_tdata, last member in the lowest bits
    typedef struct packed {
        logic [lscl_pkg::CNT_W-1:0]      misses;
        logic [lscl_pkg::CNT_W-1:0]      hits;
        logic                            hit;
        logic [lscl_pkg::SLOT_OUT_W-1:0] slot;
    } lookup_t;

    typedef struct packed {
        logic [lscl_pkg::TAG_W-1:0] sector;
        logic                       known;   // want holds a hand-written answer
        lookup_t                    want;
    } probe_row_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [lscl_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [lscl_pkg::OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the cache tags and replacement order
    logic [lscl_pkg::TAG_W-1:0] shadow_tag [lscl_pkg::SLOTS];
    bit                         shadow_valid [lscl_pkg::SLOTS];
    int                         shadow_order [lscl_pkg::SLOTS];
    logic [lscl_pkg::CNT_W-1:0] shadow_hits;
    logic [lscl_pkg::CNT_W-1:0] shadow_misses;

    lookup_t    pending_lookups [$];
    probe_row_t probe_rows [$];
    logic [lscl_pkg::TAG_W-1:0] hot_sectors [12];
    int  hot_count;
    int  fault_count = 0;
    bit  calm = 1'b0;
    bit  choke_req = 1'b0;

    lru_sector_cache_lookup dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Search from most to least recent, move the chosen slot to the front
    function automatic lookup_t lookup_sector(input logic [lscl_pkg::TAG_W-1:0] sector);
        int      pos;
        int      p;
        int      s;
        int      chosen;
        bit      found;
        bit      stop;
        lookup_t r;
        pos   = lscl_pkg::SLOTS - 1;
        found = 1'b0;
        stop  = 1'b0;
        for (p = 0; p < lscl_pkg::SLOTS; p++) begin
            s = shadow_order[p];
            if (!stop) begin
                if (!shadow_valid[s]) begin
                    pos  = p;
                    stop = 1'b1;
                end else if (shadow_tag[s] == sector) begin
                    pos   = p;
                    found = 1'b1;
                    stop  = 1'b1;
                end
            end
        end
        chosen = shadow_order[pos];
        for (p = pos; p > 0; p--)
            shadow_order[p] = shadow_order[p-1];
        shadow_order[0] = chosen;
        if (found) begin
            shadow_hits = shadow_hits + 1;
        end else begin
            shadow_misses        = shadow_misses + 1;
            shadow_tag[chosen]   = sector;
            shadow_valid[chosen] = 1'b1;
        end
        r.slot   = lscl_pkg::SLOT_OUT_W'(chosen);
        r.hit    = found;
        r.hits   = shadow_hits;
        r.misses = shadow_misses;
        return r;
    endfunction

    task automatic add_row(input logic [lscl_pkg::TAG_W-1:0] sector, input bit known,
                           input int slot, input bit hit, input int hits, input int misses);
        probe_row_t row;
        row.sector      = sector;
        row.known       = known;
        row.want.slot   = lscl_pkg::SLOT_OUT_W'(slot);
        row.want.hit    = hit;
        row.want.hits   = lscl_pkg::CNT_W'(hits);
        row.want.misses = lscl_pkg::CNT_W'(misses);
        probe_rows.push_back(row);
    endtask

    // Offer one sector beat, hold it until taken, then queue its expected result
    task automatic send_sector(input logic [lscl_pkg::TAG_W-1:0] sector, input bit known,
                               input lookup_t want);
        lookup_t predicted;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, sector};
        do @(posedge aclk); while (!s_tready);
        predicted = lookup_sector(sector);
        pending_lookups.push_back(known ? want : predicted);
    endtask

    // Mostly a small working set so hits and evictions both show up
    function automatic logic [lscl_pkg::TAG_W-1:0] pick_sector();
        if ($urandom_range(0, 99) < 75)
            return hot_sectors[$urandom_range(0, hot_count - 1)];
        return lscl_pkg::TAG_W'($urandom());
    endfunction

    task automatic check_field(input string name, input logic [lscl_pkg::CNT_W-1:0] want,
                               input logic [lscl_pkg::CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fault_count++;
        end
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        lookup_t want;
        lookup_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = lookup_t'(m_tdata[67:0]);
            if (pending_lookups.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %0h",
                         $time, got);
                fault_count++;
            end else begin
                want = pending_lookups.pop_front();
                check_field("slot", lscl_pkg::CNT_W'(want.slot), lscl_pkg::CNT_W'(got.slot));
                check_field("hit", lscl_pkg::CNT_W'(want.hit), lscl_pkg::CNT_W'(got.hit));
                check_field("hit_total", want.hits, got.hits);
                check_field("miss_total", want.misses, got.misses);
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request, none at the end
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (choke_req) begin
                m_tready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge aclk);
                choke_req = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // Sender: reset, directed table, random traffic, then drain
    initial begin
        int i;
        int j;
        lookup_t none;
        none = '0;

        for (i = 0; i < lscl_pkg::SLOTS; i++) begin
            shadow_tag[i]   = '0;
            shadow_valid[i] = 1'b0;
            shadow_order[i] = i;
        end
        shadow_hits   = '0;
        shadow_misses = '0;

        // First fills, front hit, deeper hit, full cache, then a thrashing scan
        add_row(31'h0000_0000, 1, 0, 0, 0, 1);
        add_row(31'h0000_0000, 1, 0, 1, 1, 1);
        add_row(31'h7FFF_FFFF, 1, 1, 0, 1, 2);
        add_row(31'h2AAA_AAAA, 1, 2, 0, 1, 3);
        add_row(31'h5555_5555, 1, 3, 0, 1, 4);
        add_row(31'h0000_0000, 0, 0, 0, 0, 0);
        add_row(31'h0000_0001, 0, 0, 0, 0, 0);
        add_row(31'h0000_0002, 0, 0, 0, 0, 0);
        add_row(31'h0000_0004, 0, 0, 0, 0, 0);
        add_row(31'h4000_0000, 0, 0, 0, 0, 0);
        add_row(31'h0000_0003, 0, 0, 0, 0, 0);
        add_row(31'h7FFF_FFFF, 0, 0, 0, 0, 0);
        add_row(31'h7FFF_FFFF, 0, 0, 0, 0, 0);
        for (i = 10; i <= 18; i++)
            add_row(lscl_pkg::TAG_W'(i), 0, 0, 0, 0, 0);
        add_row(31'h0000_000A, 0, 0, 0, 0, 0);
        add_row(31'h0000_0012, 0, 0, 0, 0, 0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probe_rows[k])
            send_sector(probe_rows[k].sector, probe_rows[k].known, probe_rows[k].want);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            // Refresh the working set now and then; sizes above eight force evictions
            if (i % 100 == 0) begin
                hot_count = $urandom_range(3, 12);
                for (j = 0; j < 12; j++)
                    hot_sectors[j] = $urandom_range(0, 1)
                                     ? lscl_pkg::TAG_W'($urandom_range(0, 15))
                                     : lscl_pkg::TAG_W'($urandom());
            end
            if (i == CHOKE_AT)
                choke_req = 1'b1;
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send_sector(pick_sector(), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
